// ===== hdl/ladder_button_debounce_decoder_macros.svh =====
// Assertion macros shared by the ladder keypad debounce decoder modules.
`ifndef LADDER_BUTTON_DEBOUNCE_DECODER_MACROS_SVH
`define LADDER_BUTTON_DEBOUNCE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define LBDD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lbdd assertion failed: %m");

`define LBDD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("lbdd reset assertion failed: %m");

`else

`define LBDD_ASSERT(lbl, prop)

`define LBDD_ASSERT_RST(lbl, prop)

`endif

`endif

// ===== hdl/lbdd_pkg.sv =====
// Types, constants and range decode for the ladder keypad debounce decoder.
package lbdd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int LEVEL_BITS  = 10;
    localparam int COUNT_BITS  = 10;
    localparam int LABEL_BITS  = 3;
    localparam int RANGE_COUNT = 6;

    localparam logic [LEVEL_BITS-1:0] SAMPLE_MASK = LEVEL_BITS'((1 << SAMPLE_BITS) - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] TICK_ONE    = COUNT_BITS'(1);

    localparam logic [COUNT_BITS-1:0] TICK_INTERVAL_RST  = COUNT_BITS'(10);
    localparam logic [COUNT_BITS-1:0] DEBOUNCE_LIMIT_RST = COUNT_BITS'(50);

    typedef enum logic {
        CFG_TICK_INTERVAL  = 1'b0,
        CFG_DEBOUNCE_LIMIT = 1'b1
    } t_cfg_index;

    localparam logic [LEVEL_BITS-1:0] RANGE_LO [RANGE_COUNT] = '{
        10'd950, 10'd850, 10'd700, 10'd350, 10'd200, 10'd91
    };
    localparam logic [LEVEL_BITS-1:0] RANGE_HI [RANGE_COUNT] = '{
        10'd1000, 10'd900, 10'd750, 10'd400, 10'd250, 10'd92
    };

    typedef struct packed {
        logic [COUNT_BITS-1:0] tick_interval;
        logic [COUNT_BITS-1:0] debounce_limit;
    } t_cfg;

    typedef struct packed {
        logic [LABEL_BITS-1:0] button_label;
        logic [LEVEL_BITS-1:0] stable_level;
        logic                  label_updated;
        logic                  sampled;
    } t_result;

    typedef struct packed {
        logic                  hit;
        logic [LABEL_BITS-1:0] label;
    } t_decode;

    // Last matching range wins.
    function automatic t_decode decode_range(input logic [LEVEL_BITS-1:0] v);
        t_decode d;
        d = '0;
        for (int i = 0; i < RANGE_COUNT; i++) begin
            if (v >= RANGE_LO[i] && v <= RANGE_HI[i]) begin
                d.hit   = 1'b1;
                d.label = LABEL_BITS'(i + 1);
            end
        end
        return d;
    endfunction

endpackage

// ===== hdl/lbdd_cfg.sv =====
// Configuration registers: tick interval and debounce limit.
module lbdd_cfg
    import lbdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  t_cfg_index            i_index,
    input  logic [COUNT_BITS-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_TICK_INTERVAL:  n_cfg.tick_interval  = i_data;
                CFG_DEBOUNCE_LIMIT: n_cfg.debounce_limit = i_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_interval  <= TICK_INTERVAL_RST;
            r_cfg.debounce_limit <= DEBOUNCE_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/lbdd_step.sv =====
// Tick divider, change counter, stable value and label state with one-tick update.
`include "ladder_button_debounce_decoder_macros.svh"

module lbdd_step
    import lbdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [LEVEL_BITS-1:0] i_sample,
    input  t_cfg                  i_cfg,
    output t_result               o_res
);

    logic [COUNT_BITS-1:0] r_tick_count;
    logic [COUNT_BITS-1:0] r_change_count;
    logic [LEVEL_BITS-1:0] r_stable_value;
    logic [LABEL_BITS-1:0] r_label;

    logic [COUNT_BITS-1:0] n_tick_count;
    logic [COUNT_BITS-1:0] n_change_count;
    logic [LEVEL_BITS-1:0] n_stable_value;
    logic [LABEL_BITS-1:0] n_label;

    logic                  tick_hit;
    logic [COUNT_BITS-1:0] cnt_adj;
    t_decode               dec;
    logic                  updated;

    assign tick_hit = (r_tick_count == i_cfg.tick_interval);
    assign dec      = decode_range(i_sample);

    always_comb begin
        cnt_adj = r_change_count;
        if (i_sample == r_stable_value) begin
            if (r_change_count != '0) begin
                cnt_adj = r_change_count - TICK_ONE;
            end
        end else if (r_change_count != COUNT_MAX) begin
            cnt_adj = r_change_count + TICK_ONE;
        end
    end

    always_comb begin
        n_tick_count   = r_tick_count;
        n_change_count = r_change_count;
        n_stable_value = r_stable_value;
        n_label        = r_label;
        updated        = 1'b0;
        if (i_step) begin
            if (tick_hit) begin
                n_tick_count   = TICK_ONE;
                n_change_count = cnt_adj;
                if (cnt_adj >= i_cfg.debounce_limit) begin
                    n_change_count = '0;
                    n_stable_value = i_sample;
                    if (i_sample != '0 && dec.hit) begin
                        n_label = dec.label;
                        updated = 1'b1;
                    end
                end
            end else begin
                n_tick_count = r_tick_count + TICK_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count   <= '0;
            r_change_count <= '0;
            r_stable_value <= '0;
            r_label        <= '0;
        end else begin
            r_tick_count   <= n_tick_count;
            r_change_count <= n_change_count;
            r_stable_value <= n_stable_value;
            r_label        <= n_label;
        end
    end

    assign o_res.button_label  = n_label;
    assign o_res.stable_level  = n_stable_value;
    assign o_res.label_updated = updated;
    assign o_res.sampled       = i_step && tick_hit;

    `LBDD_ASSERT(a_step_restarts_divider, o_res.sampled |=> r_tick_count == TICK_ONE)
    `LBDD_ASSERT(a_update_sets_label,
        o_res.label_updated |-> o_res.sampled && o_res.button_label != '0)
    `LBDD_ASSERT(a_idle_holds_state,
        !i_step |=> $stable(r_stable_value) && $stable(r_label) && $stable(r_tick_count))
    `LBDD_ASSERT(a_label_only_on_match,
        (i_step && !o_res.label_updated) |=> $stable(r_label))

endmodule

// ===== hdl/ladder_button_debounce_decoder.sv =====
// Ladder keypad debounce decoder top level: input and result registers around the tick logic.
`include "ladder_button_debounce_decoder_macros.svh"

// One tick per cycle: a tick is taken every cycle a sample waits and the result register can move, and its
// result passes through the input register, then the result register.
// The divider, change counter and range decode for one tick settle combinationally
// between those two registers. Configuration writes are always taken (o_cfg_ready is high)
// and must only be issued while no tick is in flight.
module ladder_button_debounce_decoder
    import lbdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_BITS-1:0] i_adc_sample,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LABEL_BITS-1:0] o_button_label,
    output logic [LEVEL_BITS-1:0] o_stable_level,
    output logic                  o_label_updated,
    output logic                  o_sampled,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_index            i_cfg_index,
    input  logic [COUNT_BITS-1:0] i_cfg_data
);

    logic                  r_in_valid;
    logic [LEVEL_BITS-1:0] r_in_sample;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  advance;
    logic                  step;
    t_cfg                  cfg;
    t_result               res;

    assign advance     = !r_out_valid || !i_stall;
    assign o_stall     = r_in_valid && !advance;
    assign step        = r_in_valid && advance;
    assign o_cfg_ready = 1'b1;

    lbdd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lbdd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_in_sample),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_sample <= LEVEL_BITS'(i_adc_sample) & SAMPLE_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_button_label  = r_out.button_label;
    assign o_stable_level  = r_out.stable_level;
    assign o_label_updated = r_out.label_updated;
    assign o_sampled       = r_out.sampled;

    `LBDD_ASSERT_RST(a_reset_clears_valid, !i_rst_n |=> !o_valid && !o_stall)
    `LBDD_ASSERT(a_stall_needs_item, o_stall |-> r_in_valid && r_out_valid)
    `LBDD_ASSERT(a_step_fills_output, step |=> o_valid)

endmodule
